### rtl/core/rpap_pkg.sv
// Shared types, widths and the arctangent table of the point rotation pipeline.
`default_nettype none

package rpap_pkg;

	localparam int COORD_BITS      = 32;
	localparam int ANGLE_BITS      = 16;
	localparam int ROTATION_STAGES = 16;
	localparam int ATAN_ENTRIES    = 24;
	localparam int CORDIC_STAGES   =
		(ROTATION_STAGES < ATAN_ENTRIES) ? ROTATION_STAGES : ATAN_ENTRIES;

	// The angle is widened to a 32-bit turn before the quadrant split.
	localparam int TURN_BITS = 32;
	// Offset from pivot, one bit wider than a coordinate so it never wraps.
	localparam int DW   = COORD_BITS + 1;
	// CORDIC vector in Q2.30 with one guard bit, angle accumulator in 2^-32 turn.
	localparam int CW   = 33;
	localparam int ZW   = 33;
	localparam int FRAC = 30;
	localparam int PW   = DW + CW;
	localparam int SW   = PW + 1;
	localparam int RW   = SW - FRAC;
	localparam int OW   = RW + 1;

	localparam logic signed [CW-1:0] INV_GAIN   = CW'(652032874);
	localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) <<< (FRAC - 1);
	localparam logic [TURN_BITS-1:0] EIGHTH_TURN = TURN_BITS'(1) << (TURN_BITS - 3);

	typedef enum logic [1:0] {
		QUAD_0   = 2'd0,
		QUAD_90  = 2'd1,
		QUAD_180 = 2'd2,
		QUAD_270 = 2'd3
	} quad_t;

	typedef struct packed {
		logic signed [DW-1:0]         dx;
		logic signed [DW-1:0]         dy;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		quad_t                        quad;
	} side_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		side_t                side;
	} cordic_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic signed [ZW-1:0] atan_turn(input int i);
		logic signed [ZW-1:0] a;
		case (i)
			0:       a = ZW'(536870912);
			1:       a = ZW'(316933406);
			2:       a = ZW'(167458907);
			3:       a = ZW'(85004756);
			4:       a = ZW'(42667331);
			5:       a = ZW'(21354465);
			6:       a = ZW'(10679838);
			7:       a = ZW'(5340245);
			8:       a = ZW'(2670163);
			9:       a = ZW'(1335087);
			10:      a = ZW'(667544);
			11:      a = ZW'(333772);
			12:      a = ZW'(166886);
			13:      a = ZW'(83443);
			14:      a = ZW'(41722);
			15:      a = ZW'(20861);
			16:      a = ZW'(10430);
			17:      a = ZW'(5215);
			18:      a = ZW'(2608);
			19:      a = ZW'(1304);
			20:      a = ZW'(652);
			21:      a = ZW'(326);
			22:      a = ZW'(163);
			23:      a = ZW'(81);
			default: a = '0;
		endcase
		return a;
	endfunction

	// One CORDIC rotation step; the shift is a constant at every call site.
	function automatic cordic_t cordic_step(input cordic_t b, input int sh);
		cordic_t              r;
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		r  = b;
		xs = b.x >>> sh;
		ys = b.y >>> sh;
		if (!b.z[ZW-1]) begin
			r.x = b.x - ys;
			r.y = b.y + xs;
			r.z = b.z - atan_turn(sh);
		end else begin
			r.x = b.x + ys;
			r.y = b.y - xs;
			r.z = b.z + atan_turn(sh);
		end
		return r;
	endfunction

	// Clamp to the signed coordinate range.
	function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [OW-1:0] v);
		logic signed [COORD_BITS-1:0] r;
		if (v[OW-1:COORD_BITS-1] == '0 || v[OW-1:COORD_BITS-1] == '1) begin
			r = v[COORD_BITS-1:0];
		end else if (v[OW-1]) begin
			r = {1'b1, {(COORD_BITS-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_BITS-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/rpap_cordic.sv
// Pipelined CORDIC rotator, one rotation step per stage, carrying the point data alongside.
`default_nettype none

module rpap_cordic import rpap_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  cordic_t in_beat,
	output logic    out_valid,
	input  logic    out_ready,
	output cordic_t out_beat
);

	logic [CORDIC_STAGES-1:0] vld_s;
	cordic_t                  beat_s [CORDIC_STAGES];
	cordic_t                  src    [CORDIC_STAGES];
	cordic_t                  nxt    [CORDIC_STAGES];
	logic [CORDIC_STAGES-1:0] src_v;
	logic [CORDIC_STAGES:0]   rdy;

	// A stage may load when it is empty or its contents move on this cycle.
	always_comb begin
		rdy[CORDIC_STAGES] = out_ready;
		for (int k = CORDIC_STAGES - 1; k >= 0; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	always_comb begin
		src[0]   = in_beat;
		src_v[0] = in_valid;
		for (int k = 1; k < CORDIC_STAGES; k++) begin
			src[k]   = beat_s[k-1];
			src_v[k] = vld_s[k-1];
		end
		for (int k = 0; k < CORDIC_STAGES; k++) begin
			nxt[k] = cordic_step(src[k], k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < CORDIC_STAGES; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= src_v[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < CORDIC_STAGES; k++) begin
			if (rdy[k] && src_v[k]) begin
				beat_s[k] <= nxt[k];
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[CORDIC_STAGES-1];
	assign out_beat  = beat_s[CORDIC_STAGES-1];

endmodule

`default_nettype wire

### rtl/core/rotate_point_about_pivot.sv
// Top level: rotates a Q16.16 point about a pivot by a binary angle, saturating the result.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------------
//  input   | in_valid / in_ready  | point_x, point_y, pivot_x, pivot_y, turn_angle
//  output  | out_valid / out_ready| rotated_x, rotated_y
//
// One beat is accepted per cycle unless a stalled output has filled the pipeline, and each
// input beat yields exactly one output beat. The pipeline stages are the input register,
// one stage per CORDIC rotation step, the product stage, the rounding stage and the
// output register; the CORDIC stage count sets the latency.
// Every stage holds its own valid bit, so a stalled output only stops the stages behind
// it once they are full, and bubbles in the pipeline still fill while a result waits.
// Reset clears all valid bits; the data registers are not reset.
`default_nettype none

module rotate_point_about_pivot import rpap_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] pivot_x,
	input  logic signed [COORD_BITS-1:0] pivot_y,
	input  logic        [ANGLE_BITS-1:0] turn_angle,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] rotated_x,
	output logic signed [COORD_BITS-1:0] rotated_y
);

	// Stage 1: input register.
	logic                         v_s1;
	logic signed [COORD_BITS-1:0] px_s1, py_s1, cx_s1, cy_s1;
	logic        [ANGLE_BITS-1:0] ang_s1;

	// Stage 2: the four products of offset and cosine/sine.
	logic                         v_s2;
	logic signed [PW-1:0]         pxc_s2, pys_s2, pxs_s2, pyc_s2;
	logic signed [COORD_BITS-1:0] cx_s2, cy_s2;

	// Stage 3: rounded rotated offsets.
	logic                         v_s3;
	logic signed [RW-1:0]         rx_s3, ry_s3;
	logic signed [COORD_BITS-1:0] cx_s3, cy_s3;

	// Stage 4: output register.
	logic                         v_s4;

	logic    rdy1, rdy2, rdy3, rdy4;
	logic    cor_in_ready, cor_out_valid;
	cordic_t cor_in, cor_out;

	logic [TURN_BITS-1:0]   full_turn, biased;
	quad_t                  quad;
	logic [TURN_BITS-1:0]   resid;
	logic signed [CW-1:0]   cos_v, sin_v;
	logic signed [SW-1:0]   sum_x, sum_y;
	logic signed [OW-1:0]   out_x, out_y;

	// Ready chain from the output back to the input.
	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || cor_in_ready;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= cor_out_valid;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			px_s1  <= point_x;
			py_s1  <= point_y;
			cx_s1  <= pivot_x;
			cy_s1  <= pivot_y;
			ang_s1 <= turn_angle;
		end
	end

	// The angle is rounded to the nearest quarter turn; the signed remainder, within
	// one eighth of a turn, is what the CORDIC stages rotate through.
	always_comb begin
		full_turn = {ang_s1, {(TURN_BITS-ANGLE_BITS){1'b0}}};
		biased    = full_turn + EIGHTH_TURN;
		quad      = quad_t'(biased[TURN_BITS-1:TURN_BITS-2]);
		resid     = full_turn - {biased[TURN_BITS-1:TURN_BITS-2], {(TURN_BITS-2){1'b0}}};

		cor_in.x         = INV_GAIN;
		cor_in.y         = '0;
		cor_in.z         = ZW'($signed(resid));
		cor_in.side.dx   = DW'(px_s1) - DW'(cx_s1);
		cor_in.side.dy   = DW'(py_s1) - DW'(cy_s1);
		cor_in.side.cx   = cx_s1;
		cor_in.side.cy   = cy_s1;
		cor_in.side.quad = quad;
	end

	rpap_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (cor_in_ready),
		.in_beat   (cor_in),
		.out_valid (cor_out_valid),
		.out_ready (rdy2),
		.out_beat  (cor_out)
	);

	// The exact quarter-turn rotation turns the CORDIC vector into cosine and sine.
	always_comb begin
		case (cor_out.side.quad)
			QUAD_90: begin
				cos_v = -cor_out.y;
				sin_v = cor_out.x;
			end
			QUAD_180: begin
				cos_v = -cor_out.x;
				sin_v = -cor_out.y;
			end
			QUAD_270: begin
				cos_v = cor_out.y;
				sin_v = -cor_out.x;
			end
			default: begin
				cos_v = cor_out.x;
				sin_v = cor_out.y;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy2 && cor_out_valid) begin
			pxc_s2 <= PW'(cor_out.side.dx) * PW'(cos_v);
			pys_s2 <= PW'(cor_out.side.dy) * PW'(sin_v);
			pxs_s2 <= PW'(cor_out.side.dx) * PW'(sin_v);
			pyc_s2 <= PW'(cor_out.side.dy) * PW'(cos_v);
			cx_s2  <= cor_out.side.cx;
			cy_s2  <= cor_out.side.cy;
		end
	end

	// Sums are exact; dropping the Q30 fraction after adding one half rounds
	// half toward positive infinity.
	always_comb begin
		sum_x = SW'(pxc_s2) - SW'(pys_s2) + ROUND_HALF;
		sum_y = SW'(pxs_s2) + SW'(pyc_s2) + ROUND_HALF;
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			rx_s3 <= sum_x[SW-1:FRAC];
			ry_s3 <= sum_y[SW-1:FRAC];
			cx_s3 <= cx_s2;
			cy_s3 <= cy_s2;
		end
	end

	always_comb begin
		out_x = OW'(rx_s3) + OW'(cx_s3);
		out_y = OW'(ry_s3) + OW'(cy_s3);
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			rotated_x <= sat_coord(out_x);
			rotated_y <= sat_coord(out_y);
		end
	end

	assign out_valid = v_s4;

endmodule

`default_nettype wire

### rtl/core/rpap_checker.sv
// Port-level assertions for the point rotation block, bound to its top level.
`default_nettype none

module rpap_checker import rpap_pkg::*; (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic signed [COORD_BITS-1:0] point_x,
	input logic signed [COORD_BITS-1:0] point_y,
	input logic signed [COORD_BITS-1:0] pivot_x,
	input logic signed [COORD_BITS-1:0] pivot_y,
	input logic        [ANGLE_BITS-1:0] turn_angle,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [COORD_BITS-1:0] rotated_x,
	input logic signed [COORD_BITS-1:0] rotated_y
);

	// A waiting input beat stays offered with its payload unchanged.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(point_x) && $stable(point_y) &&
			$stable(pivot_x) && $stable(pivot_y) && $stable(turn_angle))
		else $error("input beat changed before it was taken");

	// A waiting output beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped before it was taken");

	// A waiting output beat keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(rotated_x) && $stable(rotated_y))
		else $error("output payload changed while stalled");

	// With the output side taking beats, the pipeline never holds off the input.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while the output is draining");

	// Nothing can come out in the cycle after reset.
	a_empty_after_reset: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid right after reset");

endmodule

bind rotate_point_about_pivot rpap_checker u_rpap_checker (.*);

`default_nettype wire
